/* hw/rtl/utf16_to_utf8_transcoder_core_assert.svh */
// assertion helpers shared by the queue and back-end transcoder modules
`ifndef UTF16_TO_UTF8_TRANSCODER_CORE_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_CORE_ASSERT_SVH

// generic clocked property, ignored while reset is high
`define U16U8_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same-cycle implication
`define U16U8_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   `U16U8_ASSERT(label, clk, rst, (ante) |-> (cons), msg)

`endif

/* hw/rtl/u16u8_pkg.sv */
`timescale 1ns / 1ps

package u16u8_pkg;

   localparam int unsigned CpW        = 21;
   localparam int unsigned UnitW      = 16;
   localparam int unsigned ByteW      = 8;
   // queue depth must be a power of two, pointers wrap on overflow
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueAddrW = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [UnitW-1:0] HighFirst = 16'hD800;
   localparam logic [UnitW-1:0] HighLast  = 16'hDBFF;
   localparam logic [CpW-1:0]   SuppBase  = 21'h10000;
   localparam logic [CpW-1:0]   Lim1Byte  = 21'h00080;
   localparam logic [CpW-1:0]   Lim2Byte  = 21'h00800;
   localparam logic [CpW-1:0]   Lim3Byte  = 21'h10000;

   // encoded length minus one
   typedef enum logic [1:0] {
      LEN_ONE   = 2'd0,
      LEN_TWO   = 2'd1,
      LEN_THREE = 2'd2,
      LEN_FOUR  = 2'd3
   } len_type;

   typedef struct packed {
      logic [CpW-1:0] cp;
      len_type        len;
   } point_type;

   function automatic len_type utf8_len(input logic [CpW-1:0] cp);
      len_type l;
      if (cp < Lim1Byte) begin
         l = LEN_ONE;
      end else if (cp < Lim2Byte) begin
         l = LEN_TWO;
      end else if (cp < Lim3Byte) begin
         l = LEN_THREE;
      end else begin
         l = LEN_FOUR;
      end
      return l;
   endfunction

   function automatic logic [ByteW-1:0] utf8_byte(input logic [CpW-1:0] cp,
                                                  input len_type        len,
                                                  input logic [1:0]     idx);
      logic [1:0]       pos;
      logic [ByteW-1:0] b;
      // number of bytes still to follow this one
      pos = 2'(len) - idx;
      if (idx == 2'd0) begin
         unique case (len)
            LEN_ONE:   b = cp[7:0];
            LEN_TWO:   b = 8'hC0 | {3'b000, cp[10:6]};
            LEN_THREE: b = 8'hE0 | {4'b0000, cp[15:12]};
            LEN_FOUR:  b = 8'hF0 | {5'b00000, cp[20:18]};
         endcase
      end else begin
         case (pos)
            2'd0:    b = 8'h80 | {2'b00, cp[5:0]};
            2'd1:    b = 8'h80 | {2'b00, cp[11:6]};
            default: b = 8'h80 | {2'b00, cp[17:12]};
         endcase
      end
      return b;
   endfunction

endpackage

/* hw/rtl/u16u8_fifo.sv */
`timescale 1ns / 1ps
`include "utf16_to_utf8_transcoder_core_assert.svh"

module u16u8_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  u16u8_pkg::point_type  push_data,
   output logic                  full,
   input  logic                  pop,
   output u16u8_pkg::point_type  head_data,
   output logic                  empty
);
   import u16u8_pkg::*;

   point_type               slot_ff [QueueDepth];
   logic [QueueAddrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueueAddrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]    count_ff, count_in;

   assign full      = (count_ff == QueueCntW'(QueueDepth));
   assign empty     = (count_ff == '0);
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `U16U8_ASSERT_IMPL(a_no_push_full, clock, reset, push, !full, "push into full queue")
   `U16U8_ASSERT_IMPL(a_no_pop_empty, clock, reset, pop, !empty, "pop from empty queue")
   `U16U8_ASSERT(a_count_bound, clock, reset, count_ff <= QueueCntW'(QueueDepth), "queue overrun")

endmodule

/* hw/rtl/u16u8_front.sv */
`timescale 1ns / 1ps

module u16u8_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [u16u8_pkg::UnitW-1:0]  req_tdata,  // code_unit
   output logic                         push,
   output u16u8_pkg::point_type         push_data,
   input  logic                         full
);
   import u16u8_pkg::*;

   logic       high_pending_ff, high_pending_in;
   logic [9:0] high_bits_ff, high_bits_in;
   logic       accept;
   logic       is_high;
   logic [CpW-1:0] cp;

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;
   assign is_high    = (req_tdata >= HighFirst) && (req_tdata <= HighLast);

   always_comb begin
      // a held high half pairs with whatever unit comes next
      if (high_pending_ff) begin
         cp = SuppBase + {1'b0, high_bits_ff, req_tdata[9:0]};
      end else begin
         cp = {5'b00000, req_tdata};
      end
      push_data.cp  = cp;
      push_data.len = utf8_len(cp);
      push          = accept && (high_pending_ff || !is_high);

      high_pending_in = high_pending_ff;
      high_bits_in    = high_bits_ff;
      if (accept) begin
         if (high_pending_ff) begin
            high_pending_in = 1'b0;
            high_bits_in    = '0;
         end else if (is_high) begin
            high_pending_in = 1'b1;
            high_bits_in    = req_tdata[9:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_pending_ff <= 1'b0;
         high_bits_ff    <= '0;
      end else begin
         high_pending_ff <= high_pending_in;
         high_bits_ff    <= high_bits_in;
      end
   end

endmodule

/* hw/rtl/u16u8_back.sv */
`timescale 1ns / 1ps
`include "utf16_to_utf8_transcoder_core_assert.svh"

module u16u8_back (
   input  logic                          clock,
   input  logic                          reset,
   input  u16u8_pkg::point_type          head_data,
   input  logic                          empty,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [u16u8_pkg::ByteW-1:0]   rsp_tdata,  // out_byte
   output logic                          rsp_tlast   // last_of_point
);
   import u16u8_pkg::*;

   point_type        cur_ff, cur_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [1:0]       idx_ff, idx_in;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   logic [ByteW-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             load_out;
   logic             last_byte;
   logic             take;

   assign load_out  = !rsp_tvalid_ff || rsp_tready;
   assign last_byte = (idx_ff == 2'(cur_ff.len));
   assign take      = !empty && (!cur_valid_ff || (load_out && last_byte));
   assign pop       = take;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      cur_in        = cur_ff;
      cur_valid_in  = cur_valid_ff;
      idx_in        = idx_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;

      if (load_out) begin
         rsp_tvalid_in = cur_valid_ff;
         if (cur_valid_ff) begin
            rsp_data_in = utf8_byte(cur_ff.cp, cur_ff.len, idx_ff);
            rsp_last_in = last_byte;
            idx_in      = idx_ff + 1'b1;
            if (last_byte) begin
               cur_valid_in = 1'b0;
            end
         end
      end

      // next point moves in as the current one sends its final byte, or when no point is held
      if (take) begin
         cur_in       = head_data;
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         cur_valid_ff  <= cur_valid_in;
         idx_ff        <= idx_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   `U16U8_ASSERT_IMPL(a_idx_in_range, clock, reset, cur_valid_ff, idx_ff <= 2'(cur_ff.len), "byte index past length")
   `U16U8_ASSERT(a_point_continues, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid, "gap inside a code point")
   `U16U8_ASSERT(a_out_from_work, clock, reset, $rose(rsp_tvalid_ff) |-> $past(cur_valid_ff), "beat without work")

endmodule

/* hw/rtl/utf16_to_utf8_transcoder_core.sv */
`timescale 1ns / 1ps
// UTF-16 to UTF-8 transcoder.
// req channel: one UTF-16 code unit per beat in req_tdata. A high surrogate is held
//   and produces nothing; the next unit is taken as its low half, whatever its value.
// rsp channel: one UTF-8 byte per beat in rsp_tdata, rsp_tlast marks the final byte
//   of each code point (1 to 4 beats per point).
// A point's first byte passes through the queue, cur_ff and the output register.
// Throughput: the back end emits one byte per cycle while rsp_tready is high and
//   the queue holds points; the single byte-wide output register sets this.
// A four-entry point queue sits between the decoding front end and the byte
//   serializer, so req keeps flowing while rsp is stalled until the queue fills;
//   req_tready then drops. A stalled rsp beat holds its value.
// Reset (synchronous, active high) drops any held high surrogate, empties the
//   queue and clears rsp_tvalid; no clearing pass is needed.
module utf16_to_utf8_transcoder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [u16u8_pkg::UnitW-1:0]   req_tdata,   // [15:0] code_unit
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [u16u8_pkg::ByteW-1:0]   rsp_tdata,   // [7:0] out_byte
   output logic                          rsp_tlast    // last_of_point
);
   import u16u8_pkg::*;

   logic      push, full, pop, empty;
   point_type push_data, head_data;

   u16u8_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_data  (push_data),
      .full       (full)
   );

   u16u8_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head_data (head_data),
      .empty     (empty)
   );

   u16u8_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_data  (head_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
